### rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned DepthNowW  = 5;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned IterW      = $clog2(DataW);

  localparam logic [CmdW-1:0] CMD_PUSH = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD  = 3'd1;
  localparam logic [CmdW-1:0] CMD_SUB  = 3'd2;
  localparam logic [CmdW-1:0] CMD_MUL  = 3'd3;
  localparam logic [CmdW-1:0] CMD_DIV  = 3'd4;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_UNDER = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusW-1:0] ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [DataW-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [StatusW-1:0]      status;
    logic [DepthNowW-1:0]    depth_now;
  } rsp_t;

endpackage

### rtl/rpn_stack_calculator.sv
// Four-function RPN integer calculator on a 16-entry operand stack held in a
// small RAM. Every request returns exactly one response (value, status, depth).
// One request is worked on at a time; in_stall_o is high until the response
// has been loaded into the output register. Push, refused requests, underflow
// and unknown commands go straight to the output state; the arithmetic ops read
// both operands first, and a divide by zero ends once they are read. Multiply and divide
// iterate one bit per cycle on a single shared 33-bit adder/subtractor. The RAM
// has one registered read port, so the two operands are fetched on successive
// cycles. The output register lets a new request be accepted while the
// previous response is still stalled.
module rpn_stack_calculator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rpn_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rpn_pkg::rsp_t out_rsp_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD_R  = 4'd1;
  localparam logic [3:0] S_RD_L  = 4'd2;
  localparam logic [3:0] S_LATCH = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ABS_L = 4'd6;
  localparam logic [3:0] S_ABS_R = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DFIX  = 4'd9;
  localparam logic [3:0] S_WB    = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam int unsigned W  = rpn_pkg::DataW;
  localparam int unsigned CW = rpn_pkg::CountW;
  localparam int unsigned AW = rpn_pkg::AddrW;

  logic [3:0]                    state_q, state_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [rpn_pkg::CmdW-1:0]      cmd_q, cmd_d;
  logic [W-1:0]                  lhs_q, lhs_d;
  logic [W-1:0]                  rhs_q, rhs_d;
  logic [W-1:0]                  acc_q, acc_d;
  logic [W-1:0]                  res_q, res_d;
  logic [rpn_pkg::StatusW-1:0]   stat_q, stat_d;
  logic [rpn_pkg::IterW-1:0]     iter_q, iter_d;
  logic                          neg_q, neg_d;
  logic                          out_valid_q, out_valid_d;
  rpn_pkg::rsp_t                 out_q, out_d;

  // shared adder/subtractor
  logic [W:0] add_a, add_b, add_sum;
  logic       add_sub;
  assign add_sum = add_a + (add_b ^ {(W+1){add_sub}}) + (W+1)'(add_sub);

  // stack RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata;

  rpn_ram #(
    .WIDTH(W),
    .DEPTH(rpn_pkg::StackDepth)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic [AW-1:0] top_addr, next_addr;
  logic [W-1:0]  div_shift;
  logic          out_free;

  assign top_addr   = AW'(count_q - CW'(1));
  assign next_addr  = AW'(count_q - CW'(2));
  assign div_shift  = {acc_q[W-2:0], lhs_q[W-1]};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    acc_d       = acc_q;
    res_d       = res_q;
    stat_d      = stat_q;
    iter_d      = iter_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    add_a       = {1'b0, lhs_q};
    add_b       = {1'b0, rhs_q};
    add_sub     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = next_addr;
    ram_wdata   = res_q;
    ram_raddr   = (state_q == S_RD_R) ? top_addr : next_addr;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = in_req_i.cmd;
          res_d  = '0;
          stat_d = rpn_pkg::ST_OK;
          state_d = S_OUT;
          if (in_req_i.cmd == rpn_pkg::CMD_PUSH) begin
            if (count_q >= CW'(rpn_pkg::StackDepth)) begin
              stat_d = rpn_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(count_q);
              ram_wdata = in_req_i.operand;
              count_d   = count_q + CW'(1);
              res_d     = in_req_i.operand;
            end
          end else if (in_req_i.cmd == rpn_pkg::CMD_ADD || in_req_i.cmd == rpn_pkg::CMD_SUB ||
                       in_req_i.cmd == rpn_pkg::CMD_MUL || in_req_i.cmd == rpn_pkg::CMD_DIV) begin
            if (count_q < CW'(2)) begin
              stat_d = rpn_pkg::ST_UNDER;
            end else begin
              state_d = S_RD_R;
            end
          end
        end
      end
      S_RD_R: begin
        state_d = S_RD_L;
      end
      S_RD_L: begin
        rhs_d   = ram_rdata;
        state_d = S_LATCH;
      end
      S_LATCH: begin
        lhs_d  = ram_rdata;
        iter_d = '0;
        res_d  = '0;
        case (cmd_q)
          rpn_pkg::CMD_MUL: state_d = S_MUL;
          rpn_pkg::CMD_DIV: begin
            if (rhs_q == '0) begin
              stat_d  = rpn_pkg::ST_DIVZ;
              state_d = S_OUT;
            end else begin
              neg_d   = ram_rdata[W-1] ^ rhs_q[W-1];
              state_d = S_ABS_L;
            end
          end
          default: state_d = S_ADD;
        endcase
      end
      S_ADD: begin
        add_sub = (cmd_q == rpn_pkg::CMD_SUB);
        res_d   = add_sum[W-1:0];
        state_d = S_WB;
      end
      S_MUL: begin
        // shift-add: res accumulates, lhs is the shifted multiplicand
        add_a = {1'b0, res_q};
        add_b = {1'b0, lhs_q};
        if (rhs_q[0]) begin
          res_d = add_sum[W-1:0];
        end
        lhs_d  = {lhs_q[W-2:0], 1'b0};
        rhs_d  = {1'b0, rhs_q[W-1:1]};
        iter_d = iter_q + 1'b1;
        if (iter_q == '1) begin
          state_d = S_WB;
        end
      end
      S_ABS_L: begin
        add_a   = '0;
        add_b   = {1'b0, lhs_q};
        add_sub = 1'b1;
        if (lhs_q[W-1]) begin
          lhs_d = add_sum[W-1:0];
        end
        state_d = S_ABS_R;
      end
      S_ABS_R: begin
        add_a   = '0;
        add_b   = {1'b0, rhs_q};
        add_sub = 1'b1;
        if (rhs_q[W-1]) begin
          rhs_d = add_sum[W-1:0];
        end
        acc_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // restoring step: acc is the remainder, lhs shifts dividend out, quotient in
        add_a   = {1'b0, div_shift};
        add_b   = {1'b0, rhs_q};
        add_sub = 1'b1;
        if (!add_sum[W]) begin
          acc_d = add_sum[W-1:0];
          lhs_d = {lhs_q[W-2:0], 1'b1};
        end else begin
          acc_d = div_shift;
          lhs_d = {lhs_q[W-2:0], 1'b0};
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == '1) begin
          state_d = S_DFIX;
        end
      end
      S_DFIX: begin
        add_a   = '0;
        add_b   = {1'b0, lhs_q};
        add_sub = neg_q;
        res_d   = add_sum[W-1:0];
        state_d = S_WB;
      end
      S_WB: begin
        ram_we  = 1'b1;
        count_d = count_q - CW'(1);
        stat_d  = rpn_pkg::ST_OK;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d.value     = res_q;
          out_d.status    = stat_q;
          out_d.depth_now = rpn_pkg::DepthNowW'(count_q);
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    lhs_q  <= lhs_d;
    rhs_q  <= rhs_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    iter_q <= iter_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### rtl/rpn_ram.sv
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW      = rpn_pkg::DataW;
  localparam int unsigned CmdW       = rpn_pkg::CmdW;
  localparam int unsigned DepthNowW  = rpn_pkg::DepthNowW;
  localparam int unsigned StackDepth = rpn_pkg::StackDepth;

  localparam int unsigned RandItems    = 450;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned DrainEvery   = 150;

  typedef struct {
    rpn_pkg::req_t req;
    int unsigned   gap;
    bit            drain;  // hold this request until all responses are back
  } calc_req_t;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  rpn_pkg::req_t in_req    = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rpn_pkg::rsp_t out_rsp;

  calc_req_t     req_q[$];
  rpn_pkg::rsp_t rsp_expect_q[$];

  // shadow of the operand stack
  logic [DataW-1:0] calc_stack [StackDepth];
  int unsigned      calc_count = 0;

  int unsigned err_cnt  = 0;
  bit          quiet_tx = 1'b0;
  int unsigned tx_run   = 0;

  rpn_stack_calculator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [DataW-1:0] trunc_quot(logic [DataW-1:0] n, logic [DataW-1:0] d);
    logic [DataW-1:0] na, da, q;
    na = n[DataW-1] ? -n : n;
    da = d[DataW-1] ? -d : d;
    q  = na / da;
    return (n[DataW-1] ^ d[DataW-1]) ? -q : q;
  endfunction

  function automatic rpn_pkg::rsp_t calc_rsp(rpn_pkg::req_t r);
    rpn_pkg::rsp_t    o;
    logic [DataW-1:0] lhs, rhs, res;
    o.value  = '0;
    o.status = rpn_pkg::ST_OK;
    case (r.cmd)
      rpn_pkg::CMD_PUSH: begin
        if (calc_count >= StackDepth) begin
          o.status = rpn_pkg::ST_FULL;
        end else begin
          calc_stack[calc_count] = r.operand;
          calc_count++;
          o.value = r.operand;
        end
      end
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
        if (calc_count < 2) begin
          o.status = rpn_pkg::ST_UNDER;
        end else begin
          rhs = calc_stack[calc_count-1];
          lhs = calc_stack[calc_count-2];
          if (r.cmd == rpn_pkg::CMD_DIV && rhs == '0) begin
            o.status = rpn_pkg::ST_DIVZ;
          end else begin
            case (r.cmd)
              rpn_pkg::CMD_ADD: res = lhs + rhs;
              rpn_pkg::CMD_SUB: res = lhs - rhs;
              rpn_pkg::CMD_MUL: res = lhs * rhs;
              default:          res = trunc_quot(lhs, rhs);
            endcase
            calc_count--;
            calc_stack[calc_count-1] = res;
            o.value = res;
          end
        end
      end
      default: ;  // unknown command: no effect
    endcase
    o.depth_now = calc_count[DepthNowW-1:0];
    return o;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = {1'b1, {(DataW-1){1'b0}}};
          1:       v = {1'b0, {(DataW-1){1'b1}}};
          2:       v = '1;
          3:       v = '0;
          default: v = 1;
        endcase
      end
      1, 2:    v = int'($urandom_range(0, 8)) - 4;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [CmdW-1:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return rpn_pkg::CMD_ADD;
      1:       return rpn_pkg::CMD_SUB;
      2:       return rpn_pkg::CMD_MUL;
      default: return rpn_pkg::CMD_DIV;
    endcase
  endfunction

  task automatic add_req(logic [CmdW-1:0] c, logic [DataW-1:0] v, bit drain = 1'b0);
    calc_req_t it;
    if (tx_run == 0) begin
      quiet_tx = ($urandom_range(0, 3) == 0);
      tx_run   = $urandom_range(10, 40);
    end
    tx_run--;
    it.req.cmd     = c;
    it.req.operand = v;
    it.gap         = quiet_tx ? 0 : $urandom_range(0, 6);
    it.drain       = drain;
    req_q = {req_q, it};
  endtask

  // request driver
  calc_req_t   staged_req;
  bit          staged   = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic          nxt_valid;
    rpn_pkg::req_t nxt_req;
    rpn_pkg::rsp_t nxt_rsp;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
      staged   = 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_req   = in_req;
      if (in_valid && !in_stall) begin
        nxt_rsp      = calc_rsp(in_req);
        rsp_expect_q = {rsp_expect_q, nxt_rsp};
        nxt_valid    = 1'b0;
      end
      if (!nxt_valid) begin
        if (!staged && req_q.size() > 0 && !(req_q[0].drain && rsp_expect_q.size() > 0)) begin
          staged_req = req_q.pop_front();
          staged     = 1'b1;
          gap_left   = staged_req.gap;
        end
        if (staged) begin
          if (gap_left == 0) begin
            nxt_valid = 1'b1;
            nxt_req   = staged_req.req;
            staged    = 1'b0;
          end else begin
            gap_left--;
          end
        end
      end
      in_valid <= nxt_valid;
      in_req   <= nxt_req;
    end
  end

  // response monitor
  int unsigned stall_left = 0;
  bit          quiet_rx   = 1'b0;
  int unsigned rx_run     = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    rpn_pkg::rsp_t want;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rsp_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected response value %0d status %0d depth %0d",
                   $time, out_rsp.value, out_rsp.status, out_rsp.depth_now);
        end else begin
          want = rsp_expect_q.pop_front();
          if (out_rsp.value !== want.value) begin
            err_cnt++;
            $display("%0t: value expected %0d got %0d", $time, want.value, out_rsp.value);
          end
          if (out_rsp.status !== want.status) begin
            err_cnt++;
            $display("%0t: status expected %0d got %0d", $time, want.status, out_rsp.status);
          end
          if (out_rsp.depth_now !== want.depth_now) begin
            err_cnt++;
            $display("%0t: depth_now expected %0d got %0d",
                     $time, want.depth_now, out_rsp.depth_now);
          end
        end
        if (rx_run == 0) begin
          quiet_rx = ($urandom_range(0, 3) == 0);
          rx_run   = $urandom_range(10, 40);
        end
        rx_run--;
        stall_left = quiet_rx ? 0 : $urandom_range(0, 6);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // watchdog on handshake activity
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n, kind, len, sel;
    logic [CmdW-1:0] c;

    // empty and single-entry underflow, wraps, min / -1, divide by zero, truncation
    add_req(rpn_pkg::CMD_ADD,  '0);
    add_req(rpn_pkg::CMD_DIV,  '1);
    add_req(rpn_pkg::CMD_PUSH, 32'h7fff_ffff);
    add_req(rpn_pkg::CMD_MUL,  32'h1234_5678);
    add_req(rpn_pkg::CMD_PUSH, 32'd1);
    add_req(rpn_pkg::CMD_ADD,  '0);
    add_req(rpn_pkg::CMD_PUSH, '1);
    add_req(rpn_pkg::CMD_DIV,  '0);
    add_req(rpn_pkg::CMD_PUSH, '0);
    add_req(rpn_pkg::CMD_DIV,  '1);
    add_req(rpn_pkg::CMD_SUB,  '0);
    add_req(rpn_pkg::CMD_PUSH, 32'd7);
    add_req(rpn_pkg::CMD_PUSH, -32'sd2);
    add_req(rpn_pkg::CMD_DIV,  '0);
    add_req(rpn_pkg::CMD_PUSH, 32'h8000_0000);
    add_req(rpn_pkg::CMD_PUSH, 32'd3);
    add_req(rpn_pkg::CMD_DIV,  '0);
    add_req(rpn_pkg::CMD_MUL,  '1);
    add_req(rpn_pkg::CMD_SUB,  '0);
    add_req(CmdW'(rpn_pkg::CMD_DIV + 1), '1);
    add_req(CmdW'(rpn_pkg::CMD_DIV + 2), 32'h5555_aaaa);
    add_req(CmdW'(rpn_pkg::CMD_DIV + 3), 32'haaaa_5555);

    // bursts of pushes and operations so the stack both fills and empties
    n = 0;
    while (n < RandItems) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        sel = (kind < 4) ? 0 : (kind < 8) ? 5 : $urandom_range(0, 9);
        if (sel < 4) c = rpn_pkg::CMD_PUSH;
        else if (sel < 9) c = pick_op();
        else c = CmdW'(rpn_pkg::CMD_DIV + $urandom_range(1, 3));
        add_req(c, pick_operand(), (n % DrainEvery) == 0);
        n++;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_q.size() != 0 || staged || in_valid || rsp_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (err_cnt == 0 && rsp_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_stack_calculator.sv
tb/sv/tb_top.sv
